// File: sv/sfb_pkg.sv
// ----------------------------------------------------------------------------
// Servo command frame builder package
// Shared types, byte codes and constants of the frame builder.
// ----------------------------------------------------------------------------
package sfb_pkg;

  localparam int MaxServos  = 16;
  localparam int IdxW       = $clog2(MaxServos);
  localparam int CountW     = 5;
  localparam int LenBase    = 4;
  localparam int EntryBytes = 5;

  localparam logic [7:0] HdrFf   = 8'hff;
  localparam logic [7:0] HdrFe   = 8'hfe;
  localparam logic [7:0] InsSync = 8'h83;
  localparam logic [7:0] AddrPos = 8'h1e;
  localparam logic [7:0] DataLen = 8'h04;
  localparam logic [7:0] SumMod  = 8'hff;

  localparam logic [1:0] ModeDigital = 2'd0;
  localparam logic [1:0] ModeAnalog  = 2'd1;
  localparam logic [1:0] ModeMixed   = 2'd2;
  localparam logic [1:0] ModeInvalid = 2'd3;

  localparam logic RegMode  = 1'b0;
  localparam logic RegCount = 1'b1;

  typedef enum logic [3:0] {
    SEL_FF,
    SEL_FE,
    SEL_LEN,
    SEL_INS,
    SEL_ADR,
    SEL_DLEN,
    SEL_ID,
    SEL_PLO,
    SEL_PHI,
    SEL_SLO,
    SEL_SHI,
    SEL_CSUM,
    SEL_RID,
    SEL_RLO,
    SEL_RHI
  } sel_e;

  typedef struct packed {
    logic [7:0]  servo_id;
    logic [15:0] position;
    logic [15:0] speed;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_run;
  } out_item_t;

  typedef struct packed {
    logic load;
    sel_e sel;
    logic eor;
    logic sum_load;
    logic sum_add;
    logic rep_clr;
    logic rep_inc;
  } cmd_t;

  typedef struct packed {
    logic start_first;
    logic last;
    logic rep_last;
    logic out_free;
  } status_t;

endpackage

// File: sv/sfb_ctrl.sv
// ----------------------------------------------------------------------------
// Frame builder controller
// Byte sequencer that steps through the frame layout one byte per cycle unless the output stalls.
// ----------------------------------------------------------------------------
module sfb_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_take_i,
  input  logic [1:0]       mode_i,
  input  sfb_pkg::status_t status_i,
  output sfb_pkg::cmd_t    cmd_o,
  output logic             busy_o
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_H_FF0 = 5'd1;
  localparam logic [4:0] S_H_FF1 = 5'd2;
  localparam logic [4:0] S_H_FE  = 5'd3;
  localparam logic [4:0] S_H_LEN = 5'd4;
  localparam logic [4:0] S_H_INS = 5'd5;
  localparam logic [4:0] S_H_ADR = 5'd6;
  localparam logic [4:0] S_H_DL  = 5'd7;
  localparam logic [4:0] S_E_ID  = 5'd8;
  localparam logic [4:0] S_E_PLO = 5'd9;
  localparam logic [4:0] S_E_PHI = 5'd10;
  localparam logic [4:0] S_E_SLO = 5'd11;
  localparam logic [4:0] S_E_SHI = 5'd12;
  localparam logic [4:0] S_CSUM  = 5'd13;
  localparam logic [4:0] S_A_FE0 = 5'd14;
  localparam logic [4:0] S_A_FE1 = 5'd15;
  localparam logic [4:0] S_R_ID  = 5'd16;
  localparam logic [4:0] S_R_LO  = 5'd17;
  localparam logic [4:0] S_R_HI  = 5'd18;

  logic [4:0] state_q, state_d;
  logic       analog, mixed, adv;

  assign analog = (mode_i == sfb_pkg::ModeAnalog);
  assign mixed  = (mode_i == sfb_pkg::ModeMixed);
  assign adv    = status_i.out_free;
  assign busy_o = (state_q != S_IDLE);

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.sel     = sfb_pkg::SEL_FF;
    cmd_o.load    = adv && (state_q != S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (in_take_i) begin
          if (!status_i.start_first) state_d = S_E_ID;
          else if (analog) state_d = S_A_FE0;
          else state_d = S_H_FF0;
        end
      end
      S_H_FF0: begin
        cmd_o.sel = sfb_pkg::SEL_FF;
        if (adv) state_d = S_H_FF1;
      end
      S_H_FF1: begin
        cmd_o.sel = sfb_pkg::SEL_FF;
        if (adv) state_d = S_H_FE;
      end
      S_H_FE: begin
        cmd_o.sel      = sfb_pkg::SEL_FE;
        cmd_o.sum_load = adv;
        if (adv) state_d = S_H_LEN;
      end
      S_H_LEN: begin
        cmd_o.sel     = sfb_pkg::SEL_LEN;
        cmd_o.sum_add = adv;
        if (adv) state_d = S_H_INS;
      end
      S_H_INS: begin
        cmd_o.sel     = sfb_pkg::SEL_INS;
        cmd_o.sum_add = adv;
        if (adv) state_d = S_H_ADR;
      end
      S_H_ADR: begin
        cmd_o.sel     = sfb_pkg::SEL_ADR;
        cmd_o.sum_add = adv;
        if (adv) state_d = S_H_DL;
      end
      S_H_DL: begin
        cmd_o.sel     = sfb_pkg::SEL_DLEN;
        cmd_o.sum_add = adv;
        if (adv) state_d = S_E_ID;
      end
      S_E_ID: begin
        cmd_o.sel     = sfb_pkg::SEL_ID;
        cmd_o.sum_add = adv && !analog;
        if (adv) state_d = S_E_PLO;
      end
      S_E_PLO: begin
        cmd_o.sel     = sfb_pkg::SEL_PLO;
        cmd_o.sum_add = adv && !analog;
        if (adv) state_d = S_E_PHI;
      end
      S_E_PHI: begin
        cmd_o.sel     = sfb_pkg::SEL_PHI;
        cmd_o.sum_add = adv && !analog;
        cmd_o.eor     = analog;
        if (adv) state_d = analog ? S_IDLE : S_E_SLO;
      end
      S_E_SLO: begin
        cmd_o.sel     = sfb_pkg::SEL_SLO;
        cmd_o.sum_add = adv;
        if (adv) state_d = S_E_SHI;
      end
      S_E_SHI: begin
        cmd_o.sel     = sfb_pkg::SEL_SHI;
        cmd_o.sum_add = adv;
        cmd_o.eor     = !status_i.last;
        if (adv) state_d = status_i.last ? S_CSUM : S_IDLE;
      end
      S_CSUM: begin
        cmd_o.sel = sfb_pkg::SEL_CSUM;
        cmd_o.eor = !mixed;
        if (adv) state_d = mixed ? S_A_FE0 : S_IDLE;
      end
      S_A_FE0: begin
        cmd_o.sel     = sfb_pkg::SEL_FE;
        cmd_o.rep_clr = adv;
        if (adv) state_d = S_A_FE1;
      end
      S_A_FE1: begin
        cmd_o.sel = sfb_pkg::SEL_FE;
        if (adv) state_d = analog ? S_E_ID : S_R_ID;
      end
      S_R_ID: begin
        cmd_o.sel = sfb_pkg::SEL_RID;
        if (adv) state_d = S_R_LO;
      end
      S_R_LO: begin
        cmd_o.sel = sfb_pkg::SEL_RLO;
        if (adv) state_d = S_R_HI;
      end
      S_R_HI: begin
        cmd_o.sel     = sfb_pkg::SEL_RHI;
        cmd_o.eor     = status_i.rep_last;
        cmd_o.rep_inc = adv;
        if (adv) state_d = status_i.rep_last ? S_IDLE : S_R_ID;
      end
      default: begin
        state_d    = S_IDLE;
        cmd_o.load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: sv/sfb_datapath.sv
// ----------------------------------------------------------------------------
// Frame builder datapath
// Entry registers, id and position stores, checksum, byte select, output word.
// ----------------------------------------------------------------------------
module sfb_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_take_i,
  input  sfb_pkg::in_item_t            in_item_i,
  input  logic [sfb_pkg::CountW-1:0]   count_i,
  input  logic                         cfg_clr_i,
  input  sfb_pkg::cmd_t                cmd_i,
  input  logic                         out_stall_i,
  output logic                         out_valid_o,
  output sfb_pkg::out_item_t           out_item_o,
  output sfb_pkg::status_t             status_o
);

  logic [sfb_pkg::CountW-1:0] n, n_m1, idx_eff, entry_q, entry_d;
  logic [sfb_pkg::IdxW-1:0]   rep_q, rep_d;
  logic [7:0]                 sum_q, sum_d, byte_sel, len_byte, sum_red;
  logic                       cur_last_q, last_now, out_valid_q, out_valid_d;
  sfb_pkg::in_item_t          item_q;
  sfb_pkg::out_item_t         out_q;
  logic [7:0]                 id_mem  [sfb_pkg::MaxServos];
  logic [15:0]                pos_mem [sfb_pkg::MaxServos];
  logic [7:0]                 rd_id_q;
  logic [15:0]                rd_pos_q;

  always_comb begin
    if (count_i == '0) n = sfb_pkg::CountW'(1);
    else if (count_i > sfb_pkg::CountW'(sfb_pkg::MaxServos))
      n = sfb_pkg::CountW'(sfb_pkg::MaxServos);
    else n = count_i;
  end

  assign n_m1     = n - sfb_pkg::CountW'(1);
  assign idx_eff  = (entry_q >= n) ? '0 : entry_q;
  assign last_now = (idx_eff == n_m1);
  assign entry_d  = last_now ? '0 : idx_eff + sfb_pkg::CountW'(1);
  assign len_byte = 8'(sfb_pkg::LenBase + sfb_pkg::EntryBytes * n);
  assign sum_red  = (sum_q == sfb_pkg::SumMod) ? 8'h00 : sum_q;

  always_comb begin
    rep_d = rep_q;
    if (cmd_i.rep_clr) rep_d = '0;
    else if (cmd_i.rep_inc) rep_d = rep_q + sfb_pkg::IdxW'(1);
  end

  always_comb begin
    case (cmd_i.sel)
      sfb_pkg::SEL_FF:   byte_sel = sfb_pkg::HdrFf;
      sfb_pkg::SEL_FE:   byte_sel = sfb_pkg::HdrFe;
      sfb_pkg::SEL_LEN:  byte_sel = len_byte;
      sfb_pkg::SEL_INS:  byte_sel = sfb_pkg::InsSync;
      sfb_pkg::SEL_ADR:  byte_sel = sfb_pkg::AddrPos;
      sfb_pkg::SEL_DLEN: byte_sel = sfb_pkg::DataLen;
      sfb_pkg::SEL_ID:   byte_sel = item_q.servo_id;
      sfb_pkg::SEL_PLO:  byte_sel = item_q.position[7:0];
      sfb_pkg::SEL_PHI:  byte_sel = item_q.position[15:8];
      sfb_pkg::SEL_SLO:  byte_sel = item_q.speed[7:0];
      sfb_pkg::SEL_SHI:  byte_sel = item_q.speed[15:8];
      sfb_pkg::SEL_CSUM: byte_sel = ~sum_red;
      sfb_pkg::SEL_RID:  byte_sel = rd_id_q;
      sfb_pkg::SEL_RLO:  byte_sel = rd_pos_q[7:0];
      sfb_pkg::SEL_RHI:  byte_sel = rd_pos_q[15:8];
      default:           byte_sel = 8'h00;
    endcase
  end

  always_comb begin
    sum_d = sum_q;
    if (cfg_clr_i) sum_d = '0;
    else if (cmd_i.sum_load) sum_d = sfb_pkg::HdrFe;
    else if (cmd_i.sum_add) sum_d = sum_q + byte_sel;
  end

  assign status_o.out_free    = !out_valid_q || !out_stall_i;
  assign status_o.start_first = (idx_eff == '0);
  assign status_o.last        = cur_last_q;
  assign status_o.rep_last    = ({1'b0, rep_q} == n_m1);

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_i.load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q     <= '0;
      sum_q       <= '0;
      rep_q       <= '0;
      cur_last_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      sum_q       <= sum_d;
      rep_q       <= rep_d;
      out_valid_q <= out_valid_d;
      if (cfg_clr_i) begin
        entry_q <= '0;
      end else if (in_take_i) begin
        entry_q    <= entry_d;
        cur_last_q <= last_now;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take_i) begin
      item_q                                 <= in_item_i;
      id_mem[idx_eff[sfb_pkg::IdxW-1:0]]     <= in_item_i.servo_id;
      pos_mem[idx_eff[sfb_pkg::IdxW-1:0]]    <= in_item_i.position;
    end
    rd_id_q  <= id_mem[rep_d];
    rd_pos_q <= pos_mem[rep_d];
    if (cmd_i.load) begin
      out_q.out_byte   <= byte_sel;
      out_q.end_of_run <= cmd_i.eor;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// File: sv/servo_command_frame_builder.sv
// ----------------------------------------------------------------------------
// Servo command frame builder
// Serializes servo sync-write command frames from per-servo entry words.
//
// Input channel: one word per servo entry (id, position, speed), taken while
// in_valid_i is high and in_stall_o is low. Output channel: one frame byte
// per word, end_of_run set on the last byte caused by an input word.
// Configuration: APB registers frame_mode at 0x0 and servo_count at 0x4;
// a write drops any partly built frame.
// The input word is taken in the idle state; the sequencer state and then the
// output word register lie between it and its first byte. The sequencer emits
// one byte per cycle while the output is free: 5 bytes for a middle entry, 12
// for the first entry of a digital frame, 3 for an analog entry and 5 for the
// first analog entry; the last digital entry adds one for the checksum, and in
// mixture mode 2 + 3n more for the replayed analog frame. The sequencer then
// returns to idle, where the next word is taken. in_stall_o is high until the
// last byte of the current word is loaded. A stalled receiver holds the output
// word and the sequencer. Reset returns to digital mode, one servo per frame,
// empty frame.
module servo_command_frame_builder (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sfb_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sfb_pkg::out_item_t out_item_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [1:0]                 mode_q;
  logic [sfb_pkg::CountW-1:0] count_q;
  logic                       cfg_wr, in_take, busy;
  sfb_pkg::cmd_t              cmd;
  sfb_pkg::status_t           status;

  assign pready     = 1'b1;
  assign cfg_wr     = psel && penable && pwrite;
  assign in_stall_o = busy;
  assign in_take    = in_valid_i && !busy && (mode_q != sfb_pkg::ModeInvalid);

  always_comb begin
    unique case (paddr[2])
      sfb_pkg::RegMode:  prdata = {30'd0, mode_q};
      sfb_pkg::RegCount: prdata = {{(32 - sfb_pkg::CountW){1'b0}}, count_q};
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= sfb_pkg::ModeDigital;
      count_q <= sfb_pkg::CountW'(1);
    end else if (cfg_wr) begin
      if (paddr[2] == sfb_pkg::RegMode) mode_q <= pwdata[1:0];
      else count_q <= pwdata[sfb_pkg::CountW-1:0];
    end
  end

  sfb_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_take_i (in_take),
    .mode_i    (mode_q),
    .status_i  (status),
    .cmd_o     (cmd),
    .busy_o    (busy)
  );

  sfb_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_take_i   (in_take),
    .in_item_i   (in_item_i),
    .count_i     (count_q),
    .cfg_clr_i   (cfg_wr),
    .cmd_i       (cmd),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .status_o    (status)
  );

  a_invalid_mode_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && mode_q == sfb_pkg::ModeInvalid) |=> !in_stall_o)
    else $error("invalid mode word started the sequencer");

  a_no_load_on_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> !cmd.load)
    else $error("output word overwritten while stalled");

  a_eor_lands : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.load && cmd.eor) |=> (out_valid_o && out_item_o.end_of_run))
    else $error("end of run byte not presented");

  a_eor_frees_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.load && cmd.eor) |=> !in_stall_o)
    else $error("input still stalled after last byte of word");

endmodule

// File: sim/tb_servo_command_frame_builder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Servo command frame builder testbench
// Sends servo entry words and APB register writes, predicts every frame byte
// with a local model of the sequencer and checks each output word in order.
// Covers digital, analog, mixture and invalid modes and count limits. It also
// covers dropped frames and a checksum sum of 0xff, with random stalls on
// both channels.
// ----------------------------------------------------------------------------
module tb_servo_command_frame_builder;

  localparam int DrainCycles = 100;

  logic               clk_i;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  sfb_pkg::in_item_t  in_item_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  sfb_pkg::out_item_t out_item_o;
  logic               psel        = 1'b0;
  logic               penable     = 1'b0;
  logic               pwrite      = 1'b0;
  logic [2:0]         paddr       = '0;
  logic [31:0]        pwdata      = '0;
  logic [31:0]        prdata;
  logic               pready;

  bit          steady = 1'b0;
  int unsigned mismatch_count = 0;
  int unsigned sent_count = 0;

  logic [1:0]  cfg_mode   = sfb_pkg::ModeDigital;
  logic [4:0]  cfg_count  = 5'd1;
  logic [4:0]  frame_slot = '0;
  logic [7:0]  frame_sum  = '0;
  logic [7:0]  id_mem  [sfb_pkg::MaxServos];
  logic [15:0] pos_mem [sfb_pkg::MaxServos];
  sfb_pkg::out_item_t frame_bytes_q [$];
  sfb_pkg::out_item_t want;

  servo_command_frame_builder i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  always @(posedge clk_i) begin
    out_stall_i <= !steady && ($urandom_range(99) < 16);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (frame_bytes_q.size() == 0) begin
        $error("out_byte: expected none, actual %02h", out_item_o.out_byte);
        mismatch_count++;
      end else begin
        want = frame_bytes_q.pop_front();
        if (out_item_o.out_byte !== want.out_byte) begin
          $error("out_byte: expected %02h, actual %02h", want.out_byte, out_item_o.out_byte);
          mismatch_count++;
        end
        if (out_item_o.end_of_run !== want.end_of_run) begin
          $error("end_of_run: expected %0b, actual %0b", want.end_of_run,
                 out_item_o.end_of_run);
          mismatch_count++;
        end
      end
    end
  end

  function automatic void push_byte(input logic [7:0] b, input bit summed);
    frame_bytes_q.insert(frame_bytes_q.size(),
                         sfb_pkg::out_item_t'{out_byte: b, end_of_run: 1'b0});
    if (summed) frame_sum = frame_sum + b;
  endfunction

  function automatic void build_frame_bytes(input sfb_pkg::in_item_t it);
    int unsigned        n;
    int unsigned        base;
    logic [4:0]         slot;
    logic [7:0]         csum;
    sfb_pkg::out_item_t tail;
    bit                 last;
    if (cfg_mode == sfb_pkg::ModeInvalid) return;
    n = (cfg_count == 0) ? 1 :
        ((cfg_count > sfb_pkg::MaxServos) ? sfb_pkg::MaxServos : cfg_count);
    base = frame_bytes_q.size();
    slot = (frame_slot >= n) ? 5'd0 : frame_slot;
    last = (slot + 1 == n);
    id_mem[slot[sfb_pkg::IdxW-1:0]] = it.servo_id;
    pos_mem[slot[sfb_pkg::IdxW-1:0]] = it.position;
    if (cfg_mode == sfb_pkg::ModeAnalog) begin
      if (slot == 0) begin
        push_byte(sfb_pkg::HdrFe, 1'b0);
        push_byte(sfb_pkg::HdrFe, 1'b0);
      end
      push_byte(it.servo_id, 1'b0);
      push_byte(it.position[7:0], 1'b0);
      push_byte(it.position[15:8], 1'b0);
    end else begin
      if (slot == 0) begin
        push_byte(sfb_pkg::HdrFf, 1'b0);
        push_byte(sfb_pkg::HdrFf, 1'b0);
        frame_sum = '0;
        push_byte(sfb_pkg::HdrFe, 1'b1);
        push_byte(8'(sfb_pkg::LenBase + sfb_pkg::EntryBytes * n), 1'b1);
        push_byte(sfb_pkg::InsSync, 1'b1);
        push_byte(sfb_pkg::AddrPos, 1'b1);
        push_byte(sfb_pkg::DataLen, 1'b1);
      end
      push_byte(it.servo_id, 1'b1);
      push_byte(it.position[7:0], 1'b1);
      push_byte(it.position[15:8], 1'b1);
      push_byte(it.speed[7:0], 1'b1);
      push_byte(it.speed[15:8], 1'b1);
      if (last) begin
        csum = frame_sum % sfb_pkg::SumMod;
        push_byte(~csum, 1'b0);
        if (cfg_mode == sfb_pkg::ModeMixed) begin
          push_byte(sfb_pkg::HdrFe, 1'b0);
          push_byte(sfb_pkg::HdrFe, 1'b0);
          for (int i = 0; i < n; i++) begin
            push_byte(id_mem[i], 1'b0);
            push_byte(pos_mem[i][7:0], 1'b0);
            push_byte(pos_mem[i][15:8], 1'b0);
          end
        end
      end
    end
    frame_slot = last ? 5'd0 : slot + 5'd1;
    if (frame_bytes_q.size() > base) begin
      tail = frame_bytes_q[frame_bytes_q.size() - 1];
      tail.end_of_run = 1'b1;
      frame_bytes_q[frame_bytes_q.size() - 1] = tail;
    end
  endfunction

  function automatic sfb_pkg::in_item_t rand_entry();
    return sfb_pkg::in_item_t'{servo_id: 8'($urandom), position: 16'($urandom),
                               speed: 16'($urandom)};
  endfunction

  task automatic send_entry(input sfb_pkg::in_item_t it);
    while (!steady && $urandom_range(99) < 16) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    build_frame_bytes(it);
    if (cfg_mode != sfb_pkg::ModeInvalid) sent_count++;
  endtask

  task automatic hold_for_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (frame_bytes_q.size() != 0);
  endtask

  task automatic drain_frames();
    hold_for_results();
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic check_reg(input logic idx);
    logic [31:0] want_word;
    want_word = (idx == sfb_pkg::RegMode) ? 32'(cfg_mode) : 32'(cfg_count);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== want_word) begin
      $error("%s: expected %0h, actual %0h",
             (idx == sfb_pkg::RegMode) ? "frame_mode" : "servo_count",
             want_word, prdata);
      mismatch_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [4:0] value);
    logic [31:0] word;
    word = $urandom;
    if (idx == sfb_pkg::RegMode) word = {word[31:2], value[1:0]};
    else word = {word[31:5], value};
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    if (idx == sfb_pkg::RegMode) cfg_mode = value[1:0];
    else cfg_count = value;
    frame_slot = '0;
    frame_sum  = '0;
    check_reg(idx);
  endtask

  task automatic test_reset_state();
    check_reg(sfb_pkg::RegMode);
    check_reg(sfb_pkg::RegCount);
    send_entry(sfb_pkg::in_item_t'{servo_id: 8'hff, position: 16'hffff, speed: 16'hffff});
    drain_frames();
  endtask

  task automatic test_digital_frames();
    write_reg(sfb_pkg::RegMode, 5'(sfb_pkg::ModeDigital));
    write_reg(sfb_pkg::RegCount, 5'd2);
    send_entry(sfb_pkg::in_item_t'{servo_id: 8'h00, position: 16'h0000, speed: 16'h0000});
    send_entry(sfb_pkg::in_item_t'{servo_id: 8'hff, position: 16'haaaa, speed: 16'h5555});
    send_entry(sfb_pkg::in_item_t'{servo_id: 8'h5a, position: 16'h5555, speed: 16'haaaa});
    send_entry(rand_entry());
    drain_frames();
  endtask

  task automatic test_analog_frames();
    write_reg(sfb_pkg::RegMode, 5'(sfb_pkg::ModeAnalog));
    write_reg(sfb_pkg::RegCount, 5'd2);
    send_entry(sfb_pkg::in_item_t'{servo_id: 8'ha5, position: 16'hffff, speed: 16'hffff});
    send_entry(sfb_pkg::in_item_t'{servo_id: 8'h00, position: 16'h0000, speed: 16'h1234});
    send_entry(rand_entry());
    send_entry(rand_entry());
    drain_frames();
  endtask

  task automatic test_mixture_frames();
    write_reg(sfb_pkg::RegMode, 5'(sfb_pkg::ModeMixed));
    write_reg(sfb_pkg::RegCount, 5'd3);
    send_entry(sfb_pkg::in_item_t'{servo_id: 8'h01, position: 16'h8001, speed: 16'hffff});
    send_entry(sfb_pkg::in_item_t'{servo_id: 8'hfe, position: 16'h7ffe, speed: 16'h0000});
    send_entry(rand_entry());
    drain_frames();
  endtask

  task automatic test_count_limits();
    write_reg(sfb_pkg::RegMode, 5'(sfb_pkg::ModeDigital));
    write_reg(sfb_pkg::RegCount, 5'd0);
    // entry bytes chosen so the checksum sum lands on 0xff
    send_entry(sfb_pkg::in_item_t'{servo_id: 8'h53, position: 16'h0000, speed: 16'h0000});
    drain_frames();
    write_reg(sfb_pkg::RegCount, 5'd31);
    send_entry(rand_entry());
    drain_frames();
  endtask

  task automatic test_dropped_frame();
    write_reg(sfb_pkg::RegCount, 5'd3);
    send_entry(rand_entry());
    send_entry(rand_entry());
    drain_frames();
    write_reg(sfb_pkg::RegMode, 5'(sfb_pkg::ModeAnalog));
    send_entry(rand_entry());
    send_entry(rand_entry());
    send_entry(rand_entry());
    drain_frames();
  endtask

  task automatic test_invalid_mode();
    write_reg(sfb_pkg::RegMode, 5'(sfb_pkg::ModeInvalid));
    write_reg(sfb_pkg::RegCount, 5'd2);
    send_entry(rand_entry());
    send_entry(rand_entry());
    drain_frames();
    write_reg(sfb_pkg::RegMode, 5'(sfb_pkg::ModeDigital));
    send_entry(rand_entry());
    send_entry(rand_entry());
    drain_frames();
  endtask

  task automatic test_random_frames();
    int unsigned phase;
    int unsigned pick;
    int unsigned n;
    int unsigned items;
    logic [1:0]  mode;
    logic [4:0]  count;
    phase = 0;
    while (sent_count < 360) begin
      pick = $urandom_range(99);
      mode = (pick < 8) ? sfb_pkg::ModeInvalid : (pick < 36) ? sfb_pkg::ModeDigital :
             (pick < 64) ? sfb_pkg::ModeAnalog : sfb_pkg::ModeMixed;
      if (phase == 5 && mode == sfb_pkg::ModeInvalid) mode = sfb_pkg::ModeMixed;
      pick = $urandom_range(99);
      count = (pick < 70) ? 5'($urandom_range(1, 4)) :
              (pick < 80) ? 5'($urandom_range(5, 15)) :
              (pick < 88) ? 5'(sfb_pkg::MaxServos) :
              (pick < 94) ? 5'd0 : 5'($urandom_range(17, 31));
      n = (count == 0) ? 1 :
          ((count > sfb_pkg::MaxServos) ? sfb_pkg::MaxServos : count);
      if ($urandom_range(1)) begin
        write_reg(sfb_pkg::RegMode, 5'(mode));
        write_reg(sfb_pkg::RegCount, count);
      end else begin
        write_reg(sfb_pkg::RegCount, count);
        write_reg(sfb_pkg::RegMode, 5'(mode));
      end
      steady = (phase == 5);
      items = n * ((n > 8) ? 1 : $urandom_range(1, steady ? 12 : 4));
      if ($urandom_range(3) == 0) items += $urandom_range(1, n);
      for (int i = 0; i < items; i++) begin
        send_entry(rand_entry());
        if ((phase == 2 && i == 0) || $urandom_range(63) == 0) hold_for_results();
      end
      drain_frames();
      steady = 1'b0;
      phase++;
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_digital_frames();
    test_analog_frames();
    test_mixture_frames();
    test_count_limits();
    test_dropped_frame();
    test_invalid_mode();
    test_random_frames();
    drain_frames();
    if (mismatch_count == 0) begin
      $display("tb_servo_command_frame_builder passed");
    end else begin
      $display("tb_servo_command_frame_builder failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("tb_servo_command_frame_builder failed");
    $finish;
  end

endmodule
